@@ rtl/core/uuf_pkg.sv @@
`default_nettype none

package uuf_pkg;

    // coin-flip exponent start points
    localparam logic [10:0] SINGLE_START_EXP = 11'd126;
    localparam logic [10:0] DOUBLE_START_EXP = 11'd1022;

    // word and pool sizes
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned MANT_W      = 52;
    localparam int unsigned EXP_W       = 11;
    localparam int unsigned SP_MANT_W   = 23;
    localparam int unsigned SP_EXP_W    = 8;
    localparam int unsigned LEFT_W      = 6;

    // register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_MODE_ADDR = 3'd0;

    // assembly phase of one float
    typedef enum logic [1:0] {
        PH_EXP_SEARCH = 2'd0,
        PH_MANT_FIRST = 2'd1,
        PH_MANT_SECOND = 2'd2,
        PH_TIE_BREAK  = 2'd3
    } t_phase;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_word;
        logic emit;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/core/uuf_ctrl.sv @@
`default_nettype none

module uuf_ctrl
    import uuf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_stat,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.need_word) begin
                    n_state = ST_IDLE;
                end else if (i_stat.emit && i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_RUN: begin
                // hold a finished float until the output register frees up
                o_cmd.step = !i_stat.need_word && (!i_stat.emit || i_stat.out_free);
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/uuf_dp.sv @@
`default_nettype none

module uuf_dp
    import uuf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_stat,
    input  wire logic [WORD_W-1:0]  i_random_word,
    input  wire logic               i_mode_we,
    input  wire logic               i_mode_wdata,
    output logic                    o_mode,
    output logic [63:0]             o_float_bits,
    output logic                    o_valid,
    input  wire logic               i_ready
);

    logic                r_mode;
    logic [WORD_W-1:0]   r_word;
    logic                r_have;
    logic [WORD_W-1:0]   r_pool;
    logic [LEFT_W-1:0]   r_left;
    t_phase              r_phase;
    logic [EXP_W-1:0]    r_exp;
    logic [MANT_W-1:0]   r_mant;
    logic [63:0]         r_out;
    logic                r_out_valid;

    logic                n_have;
    logic [WORD_W-1:0]   n_pool;
    logic [LEFT_W-1:0]   n_left;
    t_phase              n_phase;
    logic [EXP_W-1:0]    n_exp;
    logic [MANT_W-1:0]   n_mant;
    logic [63:0]         n_out;

    logic                w_pool_empty;
    logic                w_coin_ok;
    logic                w_coin;
    logic                w_need;
    logic                w_emit;
    logic [EXP_W-1:0]    w_start_exp;
    logic [SP_MANT_W-1:0] w_sp_mant;
    logic [MANT_W-1:0]   w_dp_mant;

    assign w_pool_empty = (r_left == '0);
    assign w_coin_ok    = !w_pool_empty || r_have;
    assign w_coin       = w_pool_empty ? r_word[0] : r_pool[0];
    assign w_start_exp  = r_mode ? DOUBLE_START_EXP : SINGLE_START_EXP;
    assign w_sp_mant    = r_word[WORD_W-1 -: SP_MANT_W];
    assign w_dp_mant    = {r_mant[WORD_W-1:0], r_word[WORD_W-1 -: (MANT_W-WORD_W)]};

    // one micro-step: at most one coin or one mantissa word
    always_comb begin
        n_have  = r_have;
        n_pool  = r_pool;
        n_left  = r_left;
        n_phase = r_phase;
        n_exp   = r_exp;
        n_mant  = r_mant;
        w_need  = 1'b0;
        w_emit  = 1'b0;
        case (r_phase)
            PH_EXP_SEARCH: begin
                if (r_exp == '0) begin
                    n_phase = PH_MANT_FIRST;
                end else if (!w_coin_ok) begin
                    w_need = 1'b1;
                end else begin
                    if (w_coin) begin
                        n_phase = PH_MANT_FIRST;
                    end else begin
                        n_exp = r_exp - EXP_W'(1);
                    end
                end
            end
            PH_MANT_FIRST: begin
                if (!r_have) begin
                    w_need = 1'b1;
                end else begin
                    n_have = 1'b0;
                    if (r_mode) begin
                        n_mant  = {{(MANT_W-WORD_W){1'b0}}, r_word};
                        n_phase = PH_MANT_SECOND;
                    end else begin
                        n_mant = {{(MANT_W-SP_MANT_W){1'b0}}, w_sp_mant};
                        if (w_sp_mant == '0) begin
                            n_phase = PH_TIE_BREAK;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end
                end
            end
            PH_MANT_SECOND: begin
                if (!r_have) begin
                    w_need = 1'b1;
                end else begin
                    n_have = 1'b0;
                    n_mant = w_dp_mant;
                    if (w_dp_mant == '0) begin
                        n_phase = PH_TIE_BREAK;
                    end else begin
                        w_emit = 1'b1;
                    end
                end
            end
            default: begin
                // tie-break coin for a zero mantissa
                if (!w_coin_ok) begin
                    w_need = 1'b1;
                end else begin
                    n_exp  = r_exp + EXP_W'(w_coin);
                    w_emit = 1'b1;
                end
            end
        endcase

        // coin taken from the pool, refilled from the word when empty
        if (!w_need && (r_phase == PH_TIE_BREAK
                        || (r_phase == PH_EXP_SEARCH && r_exp != '0))) begin
            if (w_pool_empty) begin
                n_pool = r_word >> 1;
                n_left = LEFT_W'(WORD_W - 1);
                n_have = 1'b0;
            end else begin
                n_pool = r_pool >> 1;
                n_left = r_left - LEFT_W'(1);
            end
        end
    end

    // float assembly
    always_comb begin
        if (r_mode) begin
            n_out = {1'b0, n_exp, n_mant};
        end else begin
            n_out = {32'd0, 1'b0, n_exp[SP_EXP_W-1:0], n_mant[SP_MANT_W-1:0]};
        end
    end

    // control and work state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_have      <= 1'b0;
            r_pool      <= '0;
            r_left      <= '0;
            r_phase     <= PH_EXP_SEARCH;
            r_exp       <= SINGLE_START_EXP;
            r_mant      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_mode_we) begin
                r_mode  <= i_mode_wdata;
                r_phase <= PH_EXP_SEARCH;
                r_exp   <= i_mode_wdata ? DOUBLE_START_EXP : SINGLE_START_EXP;
                r_mant  <= '0;
            end else if (i_cmd.load) begin
                r_have <= 1'b1;
            end else if (i_cmd.step) begin
                r_pool <= n_pool;
                r_left <= n_left;
                r_have <= n_have;
                if (w_emit) begin
                    r_out_valid <= 1'b1;
                    r_phase     <= PH_EXP_SEARCH;
                    r_exp       <= w_start_exp;
                    r_mant      <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_exp   <= n_exp;
                    r_mant  <= n_mant;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_random_word;
        end
        if (i_cmd.step && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.need_word = w_need;
    assign o_stat.emit      = w_emit;
    assign o_stat.out_free  = !r_out_valid || i_ready;
    assign o_mode           = r_mode;
    assign o_float_bits     = r_out;
    assign o_valid          = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/core/uniform_unit_float_generator.sv @@
`default_nettype none

// Uniform float generator: turns a stream of 32-bit random words into IEEE
// floats in [0,1] (1.0 is possible). Each accepted word is used either as a
// 32-coin refill of the bit pool (coins taken LSB first) or as mantissa bits;
// a float needs a variable number of words (one or two mantissa words plus
// coin refills). The exponent search takes one coin per clock. After a word
// is accepted the block works through the coins still in the pool (up to
// 31), then up to 32 more once the word refills the pool, then an
// exponent-floor step and a step to ask for the next word, and only then is
// it ready to take another word from the input stream. The finished
// float sits in an output register, so the next word is accepted while a
// result waits; a second finished float holds the block until the first one
// is taken. precision_mode (address 0) selects single (0, low 32 bits used,
// upper 32 zero) or double (1); writing it restarts the float in progress but
// keeps the coin pool.
module uniform_unit_float_generator
    import uuf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [WORD_W-1:0]  i_random_word,
    input  wire logic               i_valid,
    output logic                    o_ready,
    output logic [63:0]             o_float_bits,
    output logic                    o_valid,
    input  wire logic               i_ready,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;
    logic       w_mode;
    logic       w_mode_we;

    // register write decode
    assign pready    = 1'b1;
    assign w_mode_we = psel && penable && pwrite && (paddr == REG_MODE_ADDR);

    // register read
    always_comb begin
        unique case (paddr)
            REG_MODE_ADDR: prdata = {31'd0, w_mode};
            default:       prdata = 32'd0;
        endcase
    end

    // controller
    uuf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath
    uuf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_random_word (i_random_word),
        .i_mode_we     (w_mode_we),
        .i_mode_wdata  (pwdata[0]),
        .o_mode        (w_mode),
        .o_float_bits  (o_float_bits),
        .o_valid       (o_valid),
        .i_ready       (i_ready)
    );

    // a finished float is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step && w_stat.emit |-> w_stat.out_free)
        else $error("float written into a full output register");

    // a word is not taken while another is being worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("word accepted while busy");

    // loading and stepping never overlap
    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_cmd.step)
        else $error("load and step in one cycle");

    // values are never negative, single keeps the upper half clear
    a_sign_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_float_bits[63] && (w_mode || o_float_bits[63:31] == 33'd0))
        else $error("sign bit set on output");

endmodule

`default_nettype wire

@@ dv/float_checker.sv @@
// watches the word input, the float output and the register port, predicts
// each float and compares it against what the block delivers
module float_checker
    import uuf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [WORD_W-1:0]  i_word,
    input  wire logic               i_word_valid,
    input  wire logic               i_word_ready,
    input  wire logic [63:0]        i_float_bits,
    input  wire logic               i_float_valid,
    input  wire logic               i_float_ready,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]        i_pwdata,
    input  wire logic [31:0]        i_prdata,
    input  wire logic               i_pready,
    output int                      o_mismatches,
    output int                      o_floats_owed
);

    // predictor state, mirrors the block's assembly of one float
    logic              dbl_mode = 1'b0;
    logic [WORD_W-1:0] coin_pool;
    logic [LEFT_W-1:0] coins_left;
    t_phase            phase;
    logic [EXP_W-1:0]  exp_work;
    logic [MANT_W-1:0] mant_work;
    logic              word_unused;

    logic [63:0]       float_queue[$];
    int                mismatch_cnt = 0;

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatch_cnt < 10) begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
        end
        mismatch_cnt++;
    endtask

    function automatic void restart_float();
        phase     = PH_EXP_SEARCH;
        exp_work  = dbl_mode ? DOUBLE_START_EXP : SINGLE_START_EXP;
        mant_work = '0;
    endfunction

    // returns {got a coin, coin}; refills the pool from the word when empty
    function automatic logic [1:0] draw_coin(input logic [WORD_W-1:0] word);
        logic coin;
        if (coins_left == '0) begin
            if (!word_unused) return 2'b00;
            coin_pool   = word;
            coins_left  = LEFT_W'(WORD_W);
            word_unused = 1'b0;
        end
        coin       = coin_pool[0];
        coin_pool  = coin_pool >> 1;
        coins_left = coins_left - 1'b1;
        return {1'b1, coin};
    endfunction

    // feeds one word into the float under way; returns {done, float bits}
    function automatic logic [64:0] absorb_word(input logic [WORD_W-1:0] word);
        logic [1:0]  coin;
        logic [63:0] joined;
        logic [63:0] fbits;
        logic        finished;
        word_unused = 1'b1;
        finished    = 1'b0;
        while (!finished) begin
            case (phase)
                PH_EXP_SEARCH: begin
                    // exponent floor ends the search without a coin
                    if (exp_work == '0) begin
                        phase = PH_MANT_FIRST;
                    end else begin
                        coin = draw_coin(word);
                        if (!coin[1]) return '0;
                        if (coin[0]) phase = PH_MANT_FIRST;
                        else exp_work = exp_work - 1'b1;
                    end
                end
                PH_MANT_FIRST: begin
                    if (!word_unused) return '0;
                    word_unused = 1'b0;
                    mant_work = '0;
                    if (dbl_mode) begin
                        mant_work[WORD_W-1:0] = word;
                        phase = PH_MANT_SECOND;
                    end else begin
                        mant_work[SP_MANT_W-1:0] = word[WORD_W-1 -: SP_MANT_W];
                        if (mant_work == '0) phase = PH_TIE_BREAK;
                        else finished = 1'b1;
                    end
                end
                PH_MANT_SECOND: begin
                    if (!word_unused) return '0;
                    word_unused = 1'b0;
                    joined = {mant_work[WORD_W-1:0], word};
                    mant_work = joined[63 -: MANT_W];
                    if (mant_work == '0) phase = PH_TIE_BREAK;
                    else finished = 1'b1;
                end
                PH_TIE_BREAK: begin
                    // zero mantissa: a one coin bumps the exponent
                    coin = draw_coin(word);
                    if (!coin[1]) return '0;
                    if (coin[0]) exp_work = exp_work + 1'b1;
                    finished = 1'b1;
                end
            endcase
        end
        if (dbl_mode) fbits = {1'b0, exp_work, mant_work};
        else fbits = {32'd0, 1'b0, exp_work[SP_EXP_W-1:0], mant_work[SP_MANT_W-1:0]};
        restart_float();
        return {1'b1, fbits};
    endfunction

    always @(posedge i_clk) begin : watch
        logic [64:0] outcome;
        logic [63:0] want;
        if (!i_rst_n) begin
            dbl_mode   = 1'b0;
            coin_pool  = '0;
            coins_left = '0;
            restart_float();
            float_queue.delete();
        end else begin
            // delivered float against the oldest prediction
            if (i_float_valid && i_float_ready) begin
                if (float_queue.size() == 0) begin
                    note_mismatch("unpredicted float_bits", '0, i_float_bits);
                end else begin
                    want = float_queue.pop_front();
                    if (i_float_bits !== want) note_mismatch("float_bits", want, i_float_bits);
                end
            end
            // accepted word moves the predictor on
            if (i_word_valid && i_word_ready) begin
                outcome = absorb_word(i_word);
                if (outcome[64]) float_queue.push_back(outcome[63:0]);
            end
            // register port: writes restart the float, reads return the mode
            if (i_psel && i_penable && i_pready && i_paddr == REG_MODE_ADDR) begin
                if (i_pwrite) begin
                    dbl_mode = i_pwdata[0];
                    restart_float();
                end else if (i_prdata !== {31'd0, dbl_mode}) begin
                    note_mismatch("precision_mode readback", {63'd0, dbl_mode},
                                  {32'd0, i_prdata});
                end
            end
        end
        o_floats_owed <= float_queue.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

@@ dv/testbench.sv @@
module testbench;
    import uuf_pkg::*;

    localparam logic                MODE_SINGLE   = 1'b0;
    localparam logic                MODE_DOUBLE   = 1'b1;
    localparam logic [PADDR_W-1:0]  SPARE_ADDR    = 3'd4;
    localparam int                  SETTLE_CYCLES = 96;
    localparam int                  HOLD_CYCLES   = 500;
    localparam int                  CYCLE_LIMIT   = 1000000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic [WORD_W-1:0] in_word     = '0;
    logic              in_valid    = 1'b0;
    logic              word_ready;
    logic [63:0]       float_bits;
    logic              float_valid;
    logic              float_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              calm        = 1'b0;
    int                mismatches;
    int                floats_owed;

    uniform_unit_float_generator u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_random_word (in_word),
        .i_valid       (in_valid),
        .o_ready       (word_ready),
        .o_float_bits  (float_bits),
        .o_valid       (float_valid),
        .i_ready       (float_ready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    float_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_word        (in_word),
        .i_word_valid  (in_valid),
        .i_word_ready  (word_ready),
        .i_float_bits  (float_bits),
        .i_float_valid (float_valid),
        .i_float_ready (float_ready),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_floats_owed (floats_owed)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // float sink: random stalls (none while calm), two long hold-offs to back the block up
    initial begin : sink
        int taken;
        int stall;
        taken = 0;
        forever begin
            if (taken == 60 || taken == 400) stall = HOLD_CYCLES;
            else stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                float_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            float_ready <= 1'b1;
            do @(posedge clk); while (!float_valid);
            taken++;
        end
    end

    // offer one word after a random gap (none while calm) and wait for it to be taken
    task automatic push_word(input logic [WORD_W-1:0] w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!word_ready);
    endtask

    // wait until every float has come out and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (floats_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                              input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // register write then readback, only with the block idle
    task automatic set_precision(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        drain();
        apb_access(1'b1, a, d);
        apb_access(1'b0, a, '0);
    endtask

    // random word, biased toward sparse patterns that reach the corner cases
    function automatic logic [WORD_W-1:0] draw_word();
        logic [WORD_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return r & 32'h0000_01FF;
            4: return r & 32'h0000_0FFF;
            5: return r & 32'hFFFF_FE00;
            default: return r;
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        logic [31:0] cfg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_precision(REG_MODE_ADDR, {31'd0, MODE_SINGLE});
        // unmapped address must leave the mode alone
        set_precision(SPARE_ADDR, {31'd0, MODE_DOUBLE});

        // single: half bumped to one, full and empty mantissas, exponent floor
        push_word(32'h0000_0003); push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF); push_word(32'hFFFF_FE00);
        push_word(32'h0000_01FF); push_word(32'h0000_0000);
        push_word(32'h0000_0000); push_word(32'h0000_0000);
        push_word(32'h0000_0000); push_word(32'h0000_0000);
        push_word(32'h8000_0000); push_word(32'hAAAA_AAAA);
        push_word(32'h5555_5555);

        // double: full mantissa, zero mantissa with tie-break
        set_precision(REG_MODE_ADDR, 32'hFFFF_FFFE | MODE_DOUBLE);
        push_word(32'h0000_0001); push_word(32'hFFFF_FFFF);
        push_word(32'hFFFF_FFFF); push_word(32'h0000_0000);
        push_word(32'h0000_0FFF); push_word(32'hFFFF_F000);
        push_word(32'h0000_0007); push_word(32'h0000_0000);
        push_word(32'h0000_0000); push_word(32'h0000_0003);
        push_word(32'h7FFF_FFFF); push_word(32'h0000_1000);

        // random phases, alternating precision, some without idling
        for (int p = 0; p < 7; p++) begin
            cfg    = $urandom;
            cfg[0] = (p % 2 == 1) ? MODE_DOUBLE : MODE_SINGLE;
            set_precision(REG_MODE_ADDR, cfg);
            calm = (p % 3 == 1);
            for (int n = 0; n < 125; n++) begin
                // long zero runs drive the double exponent to its floor
                if ($urandom_range(0, 59) == 0) begin
                    repeat (34) push_word('0);
                end else begin
                    push_word(draw_word());
                end
            end
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0 && floats_owed == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/uuf_pkg.sv
rtl/core/uuf_ctrl.sv
rtl/core/uuf_dp.sv
rtl/core/uniform_unit_float_generator.sv
dv/float_checker.sv
dv/testbench.sv
